// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers, sampled on clk_i and quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ----- sv/trms_pkg.sv -----
package trms_pkg;

  // Parameter defaults
  localparam int DEF_WORD_BITS  = 32;
  localparam int DEF_REG_COUNT  = 8;
  localparam int DEF_DATA_DEPTH = 1024;
  localparam int DEF_PROG_DEPTH = 256;

  // Instruction word layout
  localparam int INSTR_BITS     = 16;
  localparam int OPCODE_BITS    = 5;
  localparam int IMM_BITS       = 11;
  localparam int OP_LSB         = 0;
  localparam int IMM_LSB        = 5;
  localparam int R0_LSB         = 7;
  localparam int R1_LSB         = 10;
  localparam int R2_LSB         = 13;

  localparam logic [OPCODE_BITS-1:0] OP_ADD = 5'd0;
  localparam logic [OPCODE_BITS-1:0] OP_SUB = 5'd1;
  localparam logic [OPCODE_BITS-1:0] OP_LD  = 5'd2;
  localparam logic [OPCODE_BITS-1:0] OP_STR = 5'd3;
  localparam logic [OPCODE_BITS-1:0] OP_OUT = 5'd4;
  localparam logic [OPCODE_BITS-1:0] OP_IMM = 5'd5;
  localparam logic [OPCODE_BITS-1:0] OP_BNZ = 5'd6;
  localparam logic [OPCODE_BITS-1:0] OP_HLT = 5'd7;

  // Input item kinds
  localparam logic ITEM_LOAD = 1'b0;
  localparam logic ITEM_STEP = 1'b1;

  // Stream widths
  localparam int ADDR_BITS    = 8;
  localparam int IN_DATA_W    = 24;
  localparam int RES_BITS     = 32;
  localparam int OUT_DATA_W   = 72;

  // Result queue depth, also the limit on items in flight
  localparam int RESULT_DEPTH = 4;

  typedef struct packed {
    logic [RES_BITS-1:0] program_counter;
    logic                out_valid;
    logic [RES_BITS-1:0] out_value;
    logic                halted;
  } trms_result_t;

endpackage

// ----- sv/tiny_register_machine_step.sv -----
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tuser: kind; tdata: load_address, load_word
// m_axis    out  m_axis_tvalid/tready   tuser: out_valid; tdata: pc, out_value, halted
//
// A step passes fetch from program memory, register file read, then execute, whose
// next pc feeds the following fetch directly. s_axis_tready drops for the cycle
// after every step transfer. Every item passes the decode, execute and writeback
// registers on its way to the result queue. After reset a clearing pass zeroes all
// DATA_DEPTH words of data memory with s_axis_tready low. The pipeline never stalls:
// a 4-entry result queue absorbs m_axis back-pressure and s_axis_tready drops at
// 4 items pending.
`include "assert_macros.svh"

module tiny_register_machine_step #(
  parameter int WORD_BITS  = trms_pkg::DEF_WORD_BITS,
  parameter int REG_COUNT  = trms_pkg::DEF_REG_COUNT,
  parameter int DATA_DEPTH = trms_pkg::DEF_DATA_DEPTH,
  parameter int PROG_DEPTH = trms_pkg::DEF_PROG_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] load_address, [23:8] load_word
  input  logic [trms_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] item kind
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] program_counter, [63:32] out_value, [64] halted, [71:65] zero
  output logic [trms_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] out_valid
  output logic                            m_axis_tuser
);
  import trms_pkg::*;

  localparam int PA = $clog2(PROG_DEPTH);
  localparam int DA = $clog2(DATA_DEPTH);
  localparam int RA = $clog2(REG_COUNT);
  localparam int CW = $clog2(RESULT_DEPTH + 1);

  // Handshake
  logic                   in_acc, in_step, pop;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [ADDR_BITS-1:0]   load_addr;
  logic [INSTR_BITS-1:0]  load_word;
  logic                   load_ok;

  // Clearing pass
  logic                   clr_q;
  logic [DA-1:0]          clr_cnt_q;

  // Program memory and fetch
  logic [INSTR_BITS-1:0]  prog_mem [PROG_DEPTH];
  logic [INSTR_BITS-1:0]  prog_q;
  logic [WORD_BITS-1:0]   pc_q, pc_next, pc_fetch, e_pc;

  // Decode stage
  logic                   d_valid_q, d_step_q;
  logic [RA-1:0]          d_r1, d_r2;

  // Register file
  logic [WORD_BITS-1:0]   rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0]   rf_vld_q;
  logic [WORD_BITS-1:0]   rd_a_q, rd_b_q;
  logic                   rd_av_q, rd_bv_q;
  logic                   rf_we;
  logic [RA-1:0]          rf_waddr;
  logic [WORD_BITS-1:0]   rf_wdata;
  logic                   fw_we_q;
  logic [RA-1:0]          fw_addr_q;
  logic [WORD_BITS-1:0]   fw_data_q;

  // Execute stage
  logic                   e_valid_q, e_step_q, ex_step;
  logic [INSTR_BITS-1:0]  e_word_q;
  logic [OPCODE_BITS-1:0] e_op;
  logic [IMM_BITS-1:0]    e_imm;
  logic [RA-1:0]          e_r0, e_r1, e_r2;
  logic [WORD_BITS-1:0]   a, b;
  logic                   e_we, e_we_g, e_ld, e_dm_we, e_outv, e_halt;
  logic [RA-1:0]          e_waddr;
  logic [WORD_BITS-1:0]   e_wdata;

  // Data memory
  logic [WORD_BITS-1:0]   dm_mem [DATA_DEPTH];
  logic [WORD_BITS-1:0]   dm_q;
  logic [DA-1:0]          dm_idx;

  // Writeback stage
  logic                   m_valid_q, m_ld_q, m_we;
  logic [RA-1:0]          m_r0_q;
  trms_result_t           m_res_q, out_res;
  logic                   out_ne;

  assign load_addr     = s_axis_tdata[ADDR_BITS-1:0];
  assign load_word     = s_axis_tdata[ADDR_BITS +: INSTR_BITS];
  assign load_ok       = 32'(load_addr) < 32'(PROG_DEPTH);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_step       = (s_axis_tuser == ITEM_STEP);
  // Hold off any item while a step waits for its register operands
  assign s_axis_tready = !clr_q && (cnt_q < CW'(RESULT_DEPTH)) && !(d_valid_q && d_step_q);
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!in_acc && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // ---------------- fetch ----------------
  assign ex_step  = e_valid_q && e_step_q;
  assign pc_fetch = ex_step ? pc_next : pc_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser == ITEM_LOAD) && load_ok) begin
      prog_mem[PA'(load_addr)] <= load_word;
    end
    if (in_acc && in_step) begin
      prog_q <= prog_mem[PA'(pc_fetch)];
    end
  end

  // ---------------- register read ----------------
  assign d_r1 = prog_q[R1_LSB +: RA];
  assign d_r2 = prog_q[R2_LSB +: RA];

  assign m_we     = m_valid_q && m_ld_q;
  assign rf_we    = m_we || e_we_g;
  assign rf_waddr = m_we ? m_r0_q : e_waddr;
  assign rf_wdata = m_we ? dm_q : e_wdata;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    rd_a_q    <= rf_mem[d_r1];
    rd_b_q    <= rf_mem[d_r2];
    rd_av_q   <= rf_vld_q[d_r1];
    rd_bv_q   <= rf_vld_q[d_r2];
    fw_addr_q <= rf_waddr;
    fw_data_q <= rf_wdata;
    e_word_q  <= prog_q;
  end

  // ---------------- execute ----------------
  assign e_op  = e_word_q[OP_LSB +: OPCODE_BITS];
  assign e_imm = e_word_q[IMM_LSB +: IMM_BITS];
  assign e_r0  = e_word_q[R0_LSB +: RA];
  assign e_r1  = e_word_q[R1_LSB +: RA];
  assign e_r2  = e_word_q[R2_LSB +: RA];

  // Bypass the write that landed on the same edge as the operand read
  assign a = (fw_we_q && (fw_addr_q == e_r1)) ? fw_data_q : (rd_av_q ? rd_a_q : '0);
  assign b = (fw_we_q && (fw_addr_q == e_r2)) ? fw_data_q : (rd_bv_q ? rd_b_q : '0);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = e_r0;
    e_wdata = a;
    e_ld    = 1'b0;
    e_dm_we = 1'b0;
    e_outv  = 1'b0;
    e_halt  = 1'b0;
    pc_next = pc_q + WORD_BITS'(1);
    case (e_op)
      OP_ADD: begin
        e_we    = 1'b1;
        e_wdata = a + b;
      end
      OP_SUB: begin
        e_we    = 1'b1;
        e_wdata = a - b;
      end
      OP_LD: begin
        e_ld = 1'b1;
      end
      OP_STR: begin
        e_we    = 1'b1;
        e_dm_we = 1'b1;
      end
      OP_OUT: begin
        e_we   = 1'b1;
        e_outv = 1'b1;
      end
      OP_IMM: begin
        e_we    = 1'b1;
        e_waddr = '0;
        e_wdata = WORD_BITS'(e_imm);
      end
      OP_BNZ: begin
        if (a != '0) begin
          pc_next = b;
        end
      end
      OP_HLT: begin
        e_halt  = 1'b1;
        pc_next = pc_q;
      end
      default: begin
      end
    endcase
  end

  assign e_we_g = ex_step && e_we;
  assign e_pc   = ex_step ? pc_next : pc_q;
  assign dm_idx = DA'(a);

  // ---------------- data memory ----------------
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      dm_mem[clr_cnt_q] <= '0;
    end else if (ex_step && e_dm_we) begin
      dm_mem[dm_idx] <= b;
    end
    dm_q <= dm_mem[dm_idx];
  end

  // ---------------- writeback payload ----------------
  always_ff @(posedge clk_i) begin
    m_r0_q                  <= e_r0;
    m_res_q.program_counter <= RES_BITS'(e_pc);
    m_res_q.out_valid       <= ex_step && e_outv;
    m_res_q.out_value       <= (ex_step && e_outv) ? RES_BITS'(a) : '0;
    m_res_q.halted          <= ex_step && e_halt;
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      pc_q      <= '0;
      d_valid_q <= 1'b0;
      d_step_q  <= 1'b0;
      e_valid_q <= 1'b0;
      e_step_q  <= 1'b0;
      m_valid_q <= 1'b0;
      m_ld_q    <= 1'b0;
      rf_vld_q  <= '0;
      fw_we_q   <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (clr_q) begin
        if (clr_cnt_q == DA'(DATA_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end
      if (ex_step) begin
        pc_q <= pc_next;
      end
      d_valid_q <= in_acc;
      d_step_q  <= in_acc && in_step;
      e_valid_q <= d_valid_q;
      e_step_q  <= d_valid_q && d_step_q;
      m_valid_q <= e_valid_q;
      m_ld_q    <= ex_step && e_ld;
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      fw_we_q <= rf_we;
    end
  end

  // ---------------- result queue ----------------
  trms_res_fifo #(
    .DEPTH(RESULT_DEPTH)
  ) u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (m_valid_q),
    .push_data_i(m_res_q),
    .pop_i      (pop),
    .pop_data_o (out_res),
    .not_empty_o(out_ne)
  );

  assign m_axis_tvalid = out_ne;
  assign m_axis_tdata  = {(OUT_DATA_W - 2 * RES_BITS - 1)'(0), out_res.halted,
                          out_res.out_value, out_res.program_counter};
  assign m_axis_tuser  = out_res.out_valid;

  // ---------------- assertions ----------------
  `ASSERT_NEVER(a_rf_one_writer, m_we && e_we_g, "register file written by two stages")
  `ASSERT_CLK(a_clr_empty, clr_q |-> !(d_valid_q || e_valid_q || m_valid_q), "item during clear")
  `ASSERT_CLK(a_credit_max, cnt_q <= CW'(RESULT_DEPTH), "more items pending than queue entries")
  `ASSERT_CLK(a_step_gap, (in_acc && in_step) |=> !(in_acc && in_step), "steps back to back")

endmodule

// ----- sv/trms_res_fifo.sv -----
module trms_res_fifo #(
  parameter int DEPTH = trms_pkg::RESULT_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  trms_pkg::trms_result_t push_data_i,
  input  logic                  pop_i,
  output trms_pkg::trms_result_t pop_data_o,
  output logic                  not_empty_o
);
  import trms_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trms_result_t      entry_q [DEPTH];
  logic [AW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              pop_ok;

  assign pop_ok      = pop_i && (cnt_q != '0);
  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = entry_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_ok) begin
      rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= push_data_i;
    end
  end

endmodule

// ----- tb/sv/tiny_register_machine_step_tb.sv -----
`timescale 1ns / 100ps

module tiny_register_machine_step_tb;
  import trms_pkg::*;

  localparam int RANDOM_ITEMS = 1650;

  class step_scoreboard;
    logic [INSTR_BITS-1:0] prog_mem [DEF_PROG_DEPTH];
    bit                    written [DEF_PROG_DEPTH];
    logic [RES_BITS-1:0]   regs [DEF_REG_COUNT];
    logic [RES_BITS-1:0]   data_mem [DEF_DATA_DEPTH];
    logic [RES_BITS-1:0]   pc;
    trms_result_t          expected_results [$];
    int                    fail_count;

    function new();
      foreach (written[i]) written[i] = 1'b0;
      foreach (regs[i]) regs[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;
      pc = '0;
      fail_count = 0;
    endfunction

    // Advance the machine by one accepted transfer and queue its result.
    function void record_item(logic kind, logic [ADDR_BITS-1:0] addr,
                              logic [INSTR_BITS-1:0] word);
      trms_result_t          res;
      logic [INSTR_BITS-1:0] ins;
      logic [OPCODE_BITS-1:0] op;
      logic [IMM_BITS-1:0]   imm;
      logic [2:0]            rd, rs1, rs2;
      logic [RES_BITS-1:0]   a, b, next_pc;
      res = '0;
      if (kind == ITEM_LOAD) begin
        prog_mem[addr] = word;
        written[addr] = 1'b1;
      end else begin
        ins = prog_mem[pc % DEF_PROG_DEPTH];
        op = ins[OP_LSB +: OPCODE_BITS];
        imm = ins[IMM_LSB +: IMM_BITS];
        rd = ins[R0_LSB +: 3];
        rs1 = ins[R1_LSB +: 3];
        rs2 = ins[R2_LSB +: 3];
        a = regs[rs1];
        b = regs[rs2];
        next_pc = pc + 1;
        case (op)
          OP_ADD: regs[rd] = a + b;
          OP_SUB: regs[rd] = a - b;
          OP_LD: regs[rd] = data_mem[a % DEF_DATA_DEPTH];
          OP_STR: begin
            data_mem[a % DEF_DATA_DEPTH] = b;
            regs[rd] = a;
          end
          OP_OUT: begin
            res.out_valid = 1'b1;
            res.out_value = a;
            regs[rd] = a;
          end
          OP_IMM: regs[0] = {{(RES_BITS-IMM_BITS){1'b0}}, imm};
          OP_BNZ: if (a != '0) next_pc = b;
          OP_HLT: begin
            res.halted = 1'b1;
            next_pc = pc;
          end
          default: ;
        endcase
        pc = next_pc;
      end
      res.program_counter = pc;
      expected_results.push_back(res);
    endfunction

    function void check_step_result(logic [OUT_DATA_W-1:0] tdata, logic tuser);
      trms_result_t exp_res;
      trms_result_t got;
      got.program_counter = tdata[31:0];
      got.out_value = tdata[63:32];
      got.halted = tdata[64];
      got.out_valid = tuser;
      if (expected_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: pc=%h out_valid=%b out_value=%h halted=%b",
                   got.program_counter, got.out_valid, got.out_value, got.halted);
        fail_count++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (got !== exp_res) begin
        if (fail_count < 10)
          $display("mismatch: exp pc=%h ov=%b val=%h halt=%b, got pc=%h ov=%b val=%h halt=%b",
                   exp_res.program_counter, exp_res.out_valid, exp_res.out_value,
                   exp_res.halted, got.program_counter, got.out_valid,
                   got.out_value, got.halted);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  step_scoreboard sb;
  int             burst_left = 0;
  int             items_sent = 0;

  tiny_register_machine_step DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [INSTR_BITS-1:0] encode(logic [OPCODE_BITS-1:0] op,
                                                   logic [2:0] rd, logic [2:0] rs1,
                                                   logic [2:0] rs2);
    return {rs2, rs1, rd, 2'b00, op};
  endfunction

  function automatic logic [INSTR_BITS-1:0] random_instr();
    logic [INSTR_BITS-1:0] word;
    int                    pick;
    word = INSTR_BITS'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 8) word[4:0] = 5'($urandom_range(8, 31));
    else if (pick < 14) word[4:0] = OP_HLT;
    else if (pick < 24) word[4:0] = OP_BNZ;
    else if (pick < 40) word[4:0] = OP_IMM;
    else word[4:0] = 5'($urandom_range(0, 4));
    return word;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic kind, logic [ADDR_BITS-1:0] addr,
                           logic [INSTR_BITS-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {word, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.record_item(kind, addr, word);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Never fetch an unwritten program word; sometimes patch a halt to move on.
  task automatic run_step();
    logic [ADDR_BITS-1:0] at;
    at = sb.pc[ADDR_BITS-1:0];
    if (!sb.written[at] ||
        (sb.prog_mem[at][4:0] == OP_HLT && $urandom_range(0, 2) == 0))
      send_item(ITEM_LOAD, at, random_instr());
    send_item(ITEM_STEP, '0, INSTR_BITS'($urandom_range(0, 65535)));
  endtask

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_step_result(m_axis_tdata, m_axis_tuser);

  // Receiver: stretches of full rate, random stalls, a fixed duty pattern,
  // and solid stalls long enough to fill the result queue.
  initial begin
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 3);
      len = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(4, 40);
      for (int i = 0; i < len; i++) begin
        @(negedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (i % 4) != 0;
          default: m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    logic [INSTR_BITS-1:0] demo [9];
    logic [ADDR_BITS-1:0]  base;
    int                    len;
    int                    n;
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: largest immediate, subtract and add wrap, store and load,
    // output, taken branch to the top of the word, pc wrap through an
    // undefined opcode, then a halt that holds pc.
    demo[0] = {11'h7FF, OP_IMM};
    demo[1] = encode(OP_SUB, 3'd1, 3'd7, 3'd0);
    demo[2] = encode(OP_ADD, 3'd2, 3'd1, 3'd1);
    demo[3] = encode(OP_STR, 3'd3, 3'd1, 3'd0);
    demo[4] = encode(OP_LD, 3'd4, 3'd1, 3'd0);
    demo[5] = encode(OP_OUT, 3'd5, 3'd2, 3'd0);
    demo[6] = {11'd1, OP_IMM};
    demo[7] = encode(OP_SUB, 3'd6, 3'd7, 3'd0);
    demo[8] = encode(OP_BNZ, 3'd0, 3'd6, 3'd6);
    for (int i = 0; i < 9; i++) send_item(ITEM_LOAD, ADDR_BITS'(i), demo[i]);
    send_item(ITEM_LOAD, 8'hFF, 16'hFFFF);
    repeat (9) send_item(ITEM_STEP, '0, '0);
    send_item(ITEM_LOAD, 8'h00, encode(OP_HLT, 3'd0, 3'd0, 3'd0));
    repeat (3) send_item(ITEM_STEP, 8'hFF, 16'hFFFF);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        // Load a short program at pc, then run it.
        len = $urandom_range(3, 16);
        base = sb.pc[ADDR_BITS-1:0];
        for (int i = 0; i < len; i++)
          send_item(ITEM_LOAD, ADDR_BITS'(base + i), random_instr());
        n = $urandom_range(4, 32);
        repeat (n) run_step();
      end else begin
        n = $urandom_range(4, 16);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0)
            send_item(ITEM_LOAD, ADDR_BITS'($urandom_range(0, 255)),
                      INSTR_BITS'($urandom_range(0, 65535)));
          else
            run_step();
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
